// ===== design/slmb_pkg.sv =====
// ----------------------------------------------------------------------------
// slmb_pkg: shared types and constants of the stereo level meter
// Field widths, fixed-point constants, register indexes and the pipeline tag.
// ----------------------------------------------------------------------------
package slmb_pkg;

	localparam int BIN_W      = 10;
	localparam int LEVEL_W    = 17;
	localparam int DB_W       = 16;
	localparam int PEAK_W     = 15;
	localparam int COEF_W     = 17;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	// log2 mantissa is Q1.30, fraction has 16 bits
	localparam int MANT_W   = 31;
	localparam int LOG_FRAC = 16;
	// quotient bits of the normalization
	localparam int NORM_BITS = 16;

	// 20*log10(2) * 256 * 65536
	localparam int               LOG_K_W  = 27;
	localparam logic [LOG_K_W-1:0] LOG_DB_K = 27'd101008905;

	localparam logic [LEVEL_W-1:0]      Q16_ONE      = 17'h10000;
	localparam logic signed [DB_W-1:0]  DB_FLOOR     = -16'sd30720;
	localparam logic [DB_W-1:0]         DB_FLOOR_MAG = 16'd30720;
	// 0.1 dB in Q8.8
	localparam logic signed [17:0]      PEAK_MIN_GAP = 18'sd26;

	localparam logic [DB_W-1:0]    REACT_RESET   = 16'hCE00;
	localparam logic [PEAK_W-1:0]  PEAK_RESET    = 15'h7A00;
	localparam logic [COEF_W-1:0]  ATTACK_RESET  = 17'h10000;
	localparam logic [COEF_W-1:0]  RELEASE_RESET = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REACT   = 4'd0,
		CFG_PEAK    = 4'd1,
		CFG_ATTACK  = 4'd2,
		CFG_RELEASE = 4'd3
	} cfg_idx_t;

	typedef logic [LEVEL_W-1:0] level_t;

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic             vld;
		logic [BIN_W-1:0] bin;
		logic             restart;
	} tag_t;

endpackage

// ===== design/slmb_ifs.sv =====
// ----------------------------------------------------------------------------
// slmb_ifs: channel interfaces of the stereo level meter
// Sample input, level output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface slmb_sample_if #(parameter int SAMPLE_BITS = 24);
	logic                              valid;
	logic                              ready;
	logic signed [SAMPLE_BITS-1:0]     left_sample;
	logic signed [SAMPLE_BITS-1:0]     right_sample;
	logic                              right_present;
	logic [slmb_pkg::BIN_W-1:0]        bin_position;
	logic                              restart;

	modport source (output valid, left_sample, right_sample, right_present,
		bin_position, restart, input ready);
	modport sink (input valid, left_sample, right_sample, right_present,
		bin_position, restart, output ready);
endinterface

interface slmb_level_if;
	logic                         valid;
	logic                         ready;
	logic [slmb_pkg::LEVEL_W-1:0] raw_level;
	logic [slmb_pkg::LEVEL_W-1:0] smoothed_level;
	logic [slmb_pkg::BIN_W-1:0]   bin_echo;

	modport source (output valid, raw_level, smoothed_level, bin_echo, input ready);
	modport sink (input valid, raw_level, smoothed_level, bin_echo, output ready);
endinterface

interface slmb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [slmb_pkg::CFG_IDX_W-1:0]  index;
	logic [slmb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/slmb_ram.sv =====
// ----------------------------------------------------------------------------
// slmb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module slmb_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and read with old data on a collision
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/slmb_level.sv =====
// ----------------------------------------------------------------------------
// slmb_level: magnitude sum to dB in Q8.8
// Leading-one search, mantissa squaring log2 over 16 stages, scale to dB.
// ----------------------------------------------------------------------------
module slmb_level #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [SAMPLE_BITS:0]               sum_s1,
	input  slmb_pkg::tag_t                     tag_s1,
	output logic signed [slmb_pkg::DB_W-1:0]   db_s21,
	output slmb_pkg::tag_t                     tag_s21
);

	localparam int SUM_W = SAMPLE_BITS + 1;
	localparam int E_W   = $clog2(SUM_W);
	localparam int MW    = slmb_pkg::MANT_W;
	localparam int FW    = slmb_pkg::LOG_FRAC;
	localparam int L_W   = E_W + FW;
	localparam int P_W   = L_W + slmb_pkg::LOG_K_W;
	localparam int Q_W   = P_W - 32;
	localparam int DB_W  = slmb_pkg::DB_W;
	localparam logic [SUM_W-1:0] FLOOR_SUM =
		SUM_W'((64'd1 << SAMPLE_BITS) / 64'd1000000);
	localparam logic [L_W-1:0] FULL_L = L_W'(SAMPLE_BITS) << FW;

	// find the leading one
	logic [E_W-1:0]   e_c;
	logic [SUM_W-1:0] sum_s2;
	logic [E_W-1:0]   e_s2;
	logic             flr_s2;
	slmb_pkg::tag_t   tag_s2;

	always_comb begin
		e_c = '0;
		for (int i = 0; i < SUM_W; i++) begin
			if (sum_s1[i]) begin
				e_c = E_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_s1;
			e_s2   <= e_c;
			flr_s2 <= (sum_s1 <= FLOOR_SUM);
		end
	end

	// normalize to Q1.30; squaring stages follow
	logic [MW+SUM_W-1:0] wide_c;
	logic [5:0]          sh_l, sh_r;
	logic [MW-1:0]       mant_c;
	logic [MW-1:0]       mant_sq [FW+1];
	logic [FW-1:0]       frac_sq [FW+1];
	logic [E_W-1:0]      e_sq    [FW+1];
	logic                flr_sq  [FW+1];
	slmb_pkg::tag_t      tag_sq  [FW+1];

	assign wide_c = (MW+SUM_W)'(sum_s2);
	assign sh_l   = 6'd30 - 6'(e_s2);
	assign sh_r   = 6'(e_s2) - 6'd30;
	assign mant_c = (6'(e_s2) <= 6'd30) ? MW'(wide_c << sh_l) : MW'(wide_c >> sh_r);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_sq[0] <= '0;
		end else if (en) begin
			tag_sq[0] <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_sq[0] <= mant_c;
			frac_sq[0] <= '0;
			e_sq[0]    <= e_s2;
			flr_sq[0]  <= flr_s2;
		end
	end

	// one fraction bit per stage: square, renormalize
	for (genvar k = 0; k < FW; k++) begin : g_sq
		logic [2*MW-1:0] sq;
		logic [MW:0]     t;

		assign sq = (2*MW)'(mant_sq[k]) * (2*MW)'(mant_sq[k]);
		assign t  = sq[2*MW-1:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_sq[k+1] <= '0;
			end else if (en) begin
				tag_sq[k+1] <= tag_sq[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mant_sq[k+1] <= t[MW] ? t[MW:1] : t[MW-1:0];
				frac_sq[k+1] <= {frac_sq[k][FW-2:0], t[MW]};
				e_sq[k+1]    <= e_sq[k];
				flr_sq[k+1]  <= flr_sq[k];
			end
		end
	end

	// distance below full scale, times the dB constant
	logic [L_W-1:0] l_c, neg_c;
	logic [P_W-1:0] prod_s20;
	logic           flr_s20;
	slmb_pkg::tag_t tag_s20;

	assign l_c   = {e_sq[FW], frac_sq[FW]};
	assign neg_c = (l_c >= FULL_L) ? '0 : FULL_L - l_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s20 <= '0;
		end else if (en) begin
			tag_s20 <= tag_sq[FW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s20 <= P_W'(neg_c) * P_W'(slmb_pkg::LOG_DB_K);
			flr_s20  <= flr_sq[FW];
		end
	end

	// round, negate and floor at -120 dB
	logic [P_W-1:0]         rnd_c;
	logic [Q_W-1:0]         q_c;
	logic signed [DB_W-1:0] db_c;

	assign rnd_c = prod_s20 + (P_W'(1) << 31);
	assign q_c   = rnd_c[P_W-1:32];

	always_comb begin
		if (flr_s20 || (q_c > Q_W'(slmb_pkg::DB_FLOOR_MAG))) begin
			db_c = slmb_pkg::DB_FLOOR;
		end else begin
			db_c = -$signed(DB_W'(q_c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s21 <= '0;
		end else if (en) begin
			tag_s21 <= tag_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			db_s21 <= db_c;
		end
	end

endmodule

// ===== design/stereo_level_meter_ballistics_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_level_meter_ballistics_unit: stereo level meter with per-bin smoothing
// Level in dB, normalized to Q16, then attack/release smoothed per bin.
// ----------------------------------------------------------------------------
// Channels: sample (sink) takes a stereo pair, its bin and a restart flag;
// level (source) returns raw and smoothed Q16 levels with the bin echoed;
// cfg (sink, always ready) writes react level, peak level, attack and
// release coefficients by index. Write cfg only while no item is in flight.
// Throughput: one item per cycle unless the output stalls. The per-bin
// store is one RAM read one stage ahead of its write-back; a one-entry
// forward register covers an item whose bin was written by the item
// right before it.
// Reset: registers take their reset values, then a clearing pass writes
// all min(BIN_COUNT, 1024) store entries, one per cycle; sample.ready is
// low during the pass.
// Stall: the whole pipeline holds while a result waits in the output
// register and level.ready is low; sample.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module stereo_level_meter_ballistics_unit #(
	parameter int BIN_COUNT   = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input logic             clk,
	input logic             arst_n,
	slmb_sample_if.sink     sample,
	slmb_level_if.source    level,
	slmb_cfg_if.sink        cfg
);

	localparam int BIN_W   = slmb_pkg::BIN_W;
	localparam int LEVEL_W = slmb_pkg::LEVEL_W;
	localparam int NB      = slmb_pkg::NORM_BITS;
	localparam int DEPTH   = (BIN_COUNT < (1 << BIN_W)) ? BIN_COUNT : (1 << BIN_W);
	localparam int AW      = $clog2(DEPTH);
	localparam int ENTRY_W = LEVEL_W + 1;

	// configuration registers
	logic [slmb_pkg::DB_W-1:0]   react_q;
	logic [slmb_pkg::PEAK_W-1:0] peak_q;
	logic [slmb_pkg::COEF_W-1:0] attack_q;
	logic [slmb_pkg::COEF_W-1:0] release_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			react_q   <= slmb_pkg::REACT_RESET;
			peak_q    <= slmb_pkg::PEAK_RESET;
			attack_q  <= slmb_pkg::ATTACK_RESET;
			release_q <= slmb_pkg::RELEASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				slmb_pkg::CFG_REACT:   react_q   <= cfg.data[slmb_pkg::DB_W-1:0];
				slmb_pkg::CFG_PEAK:    peak_q    <= cfg.data[slmb_pkg::PEAK_W-1:0];
				slmb_pkg::CFG_ATTACK:  attack_q  <= cfg.data;
				slmb_pkg::CFG_RELEASE: release_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline advance and clearing pass
	logic          adv;
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic          out_vld_s41;

	assign adv          = !out_vld_s41 || level.ready;
	assign sample.ready = adv && !clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// magnitudes and their sum; mono items copy left to right
	logic [SAMPLE_BITS-1:0] mag_l, mag_r;
	logic [SAMPLE_BITS:0]   sum_s1;
	slmb_pkg::tag_t         tag_s1;

	assign mag_l = sample.left_sample[SAMPLE_BITS-1]
		? SAMPLE_BITS'(~sample.left_sample + 1'b1) : SAMPLE_BITS'(sample.left_sample);
	assign mag_r = !sample.right_present ? mag_l
		: sample.right_sample[SAMPLE_BITS-1]
		? SAMPLE_BITS'(~sample.right_sample + 1'b1) : SAMPLE_BITS'(sample.right_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.vld     <= sample.valid && sample.ready;
			tag_s1.bin     <= sample.bin_position;
			tag_s1.restart <= sample.restart;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= {1'b0, mag_l} + {1'b0, mag_r};
		end
	end

	// dB conversion
	logic signed [slmb_pkg::DB_W-1:0] db_s21;
	slmb_pkg::tag_t                   tag_s21;

	slmb_level #(.SAMPLE_BITS(SAMPLE_BITS)) u_level (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.sum_s1  (sum_s1),
		.tag_s1  (tag_s1),
		.db_s21  (db_s21),
		.tag_s21 (tag_s21)
	);

	// normalization setup: numerator, denominator, clamp flags
	logic signed [17:0] react_x, peak_x, db_x, gap_x, peff_x, num_x, den_x;

	assign react_x = {{2{react_q[15]}}, react_q};
	assign peak_x  = {{3{peak_q[14]}}, peak_q};
	assign db_x    = {{2{db_s21[15]}}, db_s21};
	assign gap_x   = react_x + slmb_pkg::PEAK_MIN_GAP;
	assign peff_x  = (peak_x < gap_x) ? gap_x : peak_x;
	assign num_x   = db_x - react_x;
	assign den_x   = peff_x - react_x;

	logic [LEVEL_W-1:0] rem_dv  [NB+1];
	logic [LEVEL_W-1:0] den_dv  [NB+1];
	logic [NB-1:0]      quo_dv  [NB+1];
	logic               zero_dv [NB+1];
	logic               sat_dv  [NB+1];
	slmb_pkg::tag_t     tag_dv  [NB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_dv[0] <= '0;
		end else if (adv) begin
			tag_dv[0] <= tag_s21;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_dv[0]  <= num_x[LEVEL_W-1:0];
			den_dv[0]  <= den_x[LEVEL_W-1:0];
			quo_dv[0]  <= '0;
			zero_dv[0] <= (num_x <= 18'sd0);
			sat_dv[0]  <= (num_x >= den_x);
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < NB; k++) begin : g_div
		logic [LEVEL_W:0] r2, rn;
		logic             ge;

		assign r2 = {rem_dv[k], 1'b0};
		assign ge = (r2 >= {1'b0, den_dv[k]});
		assign rn = ge ? (r2 - {1'b0, den_dv[k]}) : r2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_dv[k+1] <= '0;
			end else if (adv) begin
				tag_dv[k+1] <= tag_dv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_dv[k+1]  <= rn[LEVEL_W-1:0];
				den_dv[k+1]  <= den_dv[k];
				quo_dv[k+1]  <= {quo_dv[k][NB-2:0], ge};
				zero_dv[k+1] <= zero_dv[k];
				sat_dv[k+1]  <= sat_dv[k];
			end
		end
	end

	// raw level; issue the store read for this bin
	slmb_pkg::level_t raw_s39, raw_s40;
	slmb_pkg::tag_t   tag_s39, tag_s40;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s39 <= '0;
			tag_s40 <= '0;
		end else if (adv) begin
			tag_s39 <= tag_dv[NB];
			tag_s40 <= tag_s39;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s39 <= zero_dv[NB] ? '0 : sat_dv[NB] ? slmb_pkg::Q16_ONE
				: {1'b0, quo_dv[NB]};
			raw_s40 <= raw_s39;
		end
	end

	// per-bin store: {seen, smoothed}
	logic               ram_we;
	logic [AW-1:0]      ram_wa;
	logic [ENTRY_W-1:0] ram_wd, ram_rd;

	slmb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (adv),
		.rd_addr (tag_s39.bin[AW-1:0]),
		.rd_data (ram_rd)
	);

	// forward the previous write-back over the stale read
	logic                   fwd_vld_q;
	logic [BIN_W-1:0]       fwd_bin_q;
	slmb_pkg::level_t       fwd_val_q;
	logic                   hit, seen, in_rng, rising, take_raw;
	slmb_pkg::level_t       v, d, cs;
	logic [slmb_pkg::COEF_W-1:0] c;
	logic [2*LEVEL_W:0]     p;
	logic [LEVEL_W:0]       step, nv;
	slmb_pkg::level_t       sm;

	assign hit    = fwd_vld_q && (fwd_bin_q == tag_s40.bin);
	assign seen   = hit || ram_rd[LEVEL_W];
	assign v      = hit ? fwd_val_q : ram_rd[LEVEL_W-1:0];
	assign in_rng = (32'(tag_s40.bin) < 32'(BIN_COUNT));

	// attack when rising, release otherwise
	always_comb begin
		rising   = raw_s40 > v;
		c        = rising ? attack_q : release_q;
		cs       = (c > slmb_pkg::Q16_ONE) ? slmb_pkg::Q16_ONE : c;
		d        = rising ? (raw_s40 - v) : (v - raw_s40);
		p        = ((2*LEVEL_W+1)'(d) * (2*LEVEL_W+1)'(cs)) + (2*LEVEL_W+1)'(32768);
		step     = p[LEVEL_W+16:16];
		nv       = rising ? ({1'b0, v} + step) : ({1'b0, v} - step);
		take_raw = tag_s40.restart || !seen || !in_rng;
		if (take_raw) begin
			sm = raw_s40;
		end else if (nv > {1'b0, slmb_pkg::Q16_ONE}) begin
			sm = slmb_pkg::Q16_ONE;
		end else begin
			sm = nv[LEVEL_W-1:0];
		end
	end

	// write back, or clear during the pass after reset
	assign ram_we = clr_q || (adv && tag_s40.vld && in_rng);
	assign ram_wa = clr_q ? clr_cnt_q : tag_s40.bin[AW-1:0];
	assign ram_wd = clr_q ? '0 : {1'b1, sm};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (adv) begin
			fwd_vld_q <= tag_s40.vld && in_rng;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_bin_q <= tag_s40.bin;
			fwd_val_q <= sm;
		end
	end

	// output register
	slmb_pkg::level_t raw_s41, sm_s41;
	logic [BIN_W-1:0] bin_s41;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s41 <= 1'b0;
		end else if (adv) begin
			out_vld_s41 <= tag_s40.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s41 <= raw_s40;
			sm_s41  <= sm;
			bin_s41 <= tag_s40.bin;
		end
	end

	assign level.valid          = out_vld_s41;
	assign level.raw_level      = raw_s41;
	assign level.smoothed_level = sm_s41;
	assign level.bin_echo       = bin_s41;

	// checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !sample.ready)
		else $error("sample transfer possible during store clearing");

	a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && tag_s40.vld) |-> !clr_q)
		else $error("item write-back collides with clearing pass");

	a_smoothed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_s41 |-> (sm_s41 <= slmb_pkg::Q16_ONE && raw_s41 <= slmb_pkg::Q16_ONE))
		else $error("level above full scale");

	a_out_of_range_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_s41 && (32'(bin_s41) >= 32'(BIN_COUNT))) |-> (sm_s41 == raw_s41))
		else $error("out-of-range bin was smoothed");

endmodule
